// ----- src/evpm_pkg.sv -----
`timescale 1ns / 1ps

package evpm_pkg;

   localparam int VOICES_DEF      = 8;
   localparam int FRAME_DEPTH_DEF = 16384;
   localparam int ADDR_MAX_W      = 20;

   // request function codes
   localparam logic [2:0] FUNC_LOAD  = 3'd0;
   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_GAINS = 3'd2;
   localparam logic [2:0] FUNC_STOP  = 3'd3;
   localparam logic [2:0] FUNC_QUERY = 3'd4;
   localparam logic [2:0] FUNC_MIX   = 3'd5;

   // response kinds
   localparam logic [1:0] KIND_MIX    = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic [2:0]         func;
      logic [2:0]         voice;
      logic [13:0]        frame_address;
      logic [14:0]        frame_count;
      logic signed [15:0] load_left;
      logic signed [15:0] load_right;
      logic [6:0]         volume;
      logic [7:0]         separation;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic signed [15:0] mix_left;
      logic signed [15:0] mix_right;
      logic               flag;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_GAIN_MUL,
      ST_GAIN_DIV,
      ST_MIX_RUN,
      ST_MIX_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic ram_load;
      logic voice_stop;
      logic gain_mul;
      logic gain_write;
      logic start_write;
      logic mix_clear;
      logic mix_issue;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       vok;
      logic       start_ok;
      logic       pipe_busy;
      logic       last_voice;
      logic       out_free;
   } status_type;

   // 14-bit address modulo depth, depth at least 256
   function automatic logic [ADDR_MAX_W-1:0] wrap_addr(input logic [13:0] addr,
                                                       input int unsigned depth);
      logic [26:0] x;
      logic [26:0] step;
      x = 27'(addr);
      for (int k = 5; k >= 0; k--) begin
         step = 27'(depth) << k;
         if (x >= step) begin
            x = x - step;
         end
      end
      return x[ADDR_MAX_W-1:0];
   endfunction

endpackage

// ----- src/evpm_ram.sv -----
`timescale 1ns / 1ps

module evpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/evpm_ctrl.sv -----
`timescale 1ns / 1ps

module evpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  evpm_pkg::status_type   status,
   output evpm_pkg::cmd_type      cmd
);

   import evpm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.func)
               FUNC_START: begin
                  state_in = status.start_ok ? ST_GAIN_MUL : ST_RESP;
               end
               FUNC_GAINS: begin
                  state_in = status.vok ? ST_GAIN_MUL : ST_IDLE;
               end
               FUNC_QUERY: state_in = ST_RESP;
               FUNC_MIX:   state_in = ST_MIX_RUN;
               default:    state_in = ST_IDLE;
            endcase
         end
         ST_GAIN_MUL: state_in = ST_GAIN_DIV;
         ST_GAIN_DIV: begin
            state_in = (status.func == FUNC_START) ? ST_RESP : ST_IDLE;
         end
         ST_MIX_RUN: begin
            if (status.last_voice) begin
               state_in = ST_MIX_DRAIN;
            end
         end
         ST_MIX_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            case (status.func)
               FUNC_LOAD: cmd.ram_load   = 1'b1;
               FUNC_STOP: cmd.voice_stop = status.vok;
               FUNC_MIX:  cmd.mix_clear  = 1'b1;
               default:   cmd.ram_load   = 1'b0;
            endcase
         end
         ST_GAIN_MUL: cmd.gain_mul = 1'b1;
         ST_GAIN_DIV: begin
            cmd.gain_write  = 1'b1;
            cmd.start_write = (status.func == FUNC_START);
         end
         ST_MIX_RUN:   cmd.mix_issue = 1'b1;
         ST_MIX_DRAIN: cmd.mix_issue = 1'b0;
         ST_RESP:      cmd.rsp_load  = status.out_free;
         default:      cmd.capture   = 1'b0;
      endcase
   end

endmodule

// ----- src/evpm_datapath.sv -----
`timescale 1ns / 1ps

module evpm_datapath #(
   parameter int VOICES      = evpm_pkg::VOICES_DEF,
   parameter int FRAME_DEPTH = evpm_pkg::FRAME_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  evpm_pkg::req_type      req_data,
   input  evpm_pkg::cmd_type      cmd,
   output evpm_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output evpm_pkg::rsp_type      rsp_data
);

   import evpm_pkg::*;

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int AW = $clog2(FRAME_DEPTH);
   localparam logic [AW-1:0] DEPTH_LAST = AW'(FRAME_DEPTH - 1);
   localparam logic [VW-1:0] VOICE_LAST = VW'(VOICES - 1);

   // p / 127 for p below 32512, reciprocal estimate plus one correction
   function automatic logic [7:0] div127(input logic [14:0] p);
      logic [24:0] scaled;
      logic [7:0]  q0;
      logic [15:0] rem;
      scaled = ({10'b0, p} << 9) + ({10'b0, p} << 2);
      q0     = scaled[23:16];
      rem    = {1'b0, p} - (({8'b0, q0} << 7) - {8'b0, q0});
      return (rem >= 16'd127) ? q0 + 8'd1 : q0;
   endfunction

   // captured request
   req_type req_ff;

   // per-voice state
   logic          active_ff [VOICES];
   logic          active_in [VOICES];
   logic [14:0]   remain_ff [VOICES];
   logic [14:0]   remain_in [VOICES];
   logic [AW-1:0] cur_ff    [VOICES];
   logic [AW-1:0] cur_in    [VOICES];
   logic [7:0]    gain_l_ff [VOICES];
   logic [7:0]    gain_l_in [VOICES];
   logic [7:0]    gain_r_ff [VOICES];
   logic [7:0]    gain_r_in [VOICES];

   logic [5:0]    voice_wide;
   logic [VW-1:0] voice_idx;
   logic [VW-1:0] sel;
   logic          vok;
   logic [ADDR_MAX_W-1:0] addr_wrapped;
   logic [AW-1:0] cur_next;

   // gain products
   logic [14:0] gprod_l_ff;
   logic [14:0] gprod_r_ff;

   // mix pipeline
   logic [VW-1:0] mix_idx_ff;
   logic          rd_valid_ff;
   logic [VW-1:0] rd_idx_ff;
   logic          prod_valid_ff;
   logic signed [23:0] prod_l_ff;
   logic signed [23:0] prod_r_ff;
   logic signed [24:0] prod_l_full;
   logic signed [24:0] prod_r_full;
   logic          quo_valid_ff;
   logic [22:0]   mag_l_ff;
   logic [22:0]   mag_r_ff;
   logic [15:0]   q0_l_ff;
   logic [15:0]   q0_r_ff;
   logic          neg_l_ff;
   logic          neg_r_ff;
   logic [23:0]   abs_l;
   logic [23:0]   abs_r;
   logic [31:0]   scl_l;
   logic [31:0]   scl_r;
   logic signed [15:0] acc_l_ff;
   logic signed [15:0] acc_r_ff;
   logic signed [15:0] acc_l_in;
   logic signed [15:0] acc_r_in;

   // frame memory
   logic          ram_we;
   logic          ram_re;
   logic [31:0]   ram_rdata;

   // response register
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   assign voice_wide   = {3'b000, req_ff.voice};
   assign voice_idx    = voice_wide[VW-1:0];
   assign vok          = (voice_wide < 6'(VOICES));
   assign sel          = cmd.mix_issue ? mix_idx_ff : voice_idx;
   assign addr_wrapped = wrap_addr(req_ff.frame_address, FRAME_DEPTH);
   assign cur_next     = (cur_ff[sel] == DEPTH_LAST) ? '0 : cur_ff[sel] + 1'b1;

   assign ram_we = cmd.ram_load;
   assign ram_re = cmd.mix_issue && active_ff[sel] && (remain_ff[sel] != 15'd0);

   evpm_ram #(
      .WIDTH (32),
      .DEPTH (FRAME_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_wrapped[AW-1:0]),
      .wr_data ({req_ff.load_right, req_ff.load_left}),
      .rd_en   (ram_re),
      .rd_addr (cur_ff[sel]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // voice state update
   always_comb begin
      for (int i = 0; i < VOICES; i++) begin
         active_in[i] = active_ff[i];
         remain_in[i] = remain_ff[i];
         cur_in[i]    = cur_ff[i];
         gain_l_in[i] = gain_l_ff[i];
         gain_r_in[i] = gain_r_ff[i];
      end
      if (cmd.voice_stop) begin
         active_in[sel] = 1'b0;
      end
      if (cmd.gain_write) begin
         gain_l_in[sel] = div127(gprod_l_ff);
         gain_r_in[sel] = div127(gprod_r_ff);
      end
      if (cmd.start_write) begin
         active_in[sel] = 1'b1;
         remain_in[sel] = req_ff.frame_count;
         cur_in[sel]    = addr_wrapped[AW-1:0];
      end
      if (cmd.mix_issue && active_ff[sel]) begin
         if (remain_ff[sel] == 15'd0) begin
            active_in[sel] = 1'b0;
         end else begin
            remain_in[sel] = remain_ff[sel] - 15'd1;
            cur_in[sel]    = cur_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) begin
            active_ff[i] <= 1'b0;
            remain_ff[i] <= '0;
            cur_ff[i]    <= '0;
            gain_l_ff[i] <= '0;
            gain_r_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < VOICES; i++) begin
            active_ff[i] <= active_in[i];
            remain_ff[i] <= remain_in[i];
            cur_ff[i]    <= cur_in[i];
            gain_l_ff[i] <= gain_l_in[i];
            gain_r_ff[i] <= gain_r_in[i];
         end
      end
   end

   // gain products, left side clamps to zero past full right
   always_ff @(posedge clock) begin
      if (cmd.gain_mul) begin
         if (req_ff.separation > 8'd254) begin
            gprod_l_ff <= '0;
         end else begin
            gprod_l_ff <= 15'(8'd254 - req_ff.separation) * 15'(req_ff.volume);
         end
         gprod_r_ff <= 15'(req_ff.separation) * 15'(req_ff.volume);
      end
   end

   // stage 1: sample times gain
   assign prod_l_full = $signed(ram_rdata[15:0])  * $signed({1'b0, gain_l_ff[rd_idx_ff]});
   assign prod_r_full = $signed(ram_rdata[31:16]) * $signed({1'b0, gain_r_ff[rd_idx_ff]});

   // stage 2: magnitude and quotient estimate for / 255
   assign abs_l = prod_l_ff[23] ? 24'(-prod_l_ff) : prod_l_ff;
   assign abs_r = prod_r_ff[23] ? 24'(-prod_r_ff) : prod_r_ff;
   assign scl_l = {9'b0, abs_l[22:0]} + ({9'b0, abs_l[22:0]} << 8);
   assign scl_r = {9'b0, abs_r[22:0]} + ({9'b0, abs_r[22:0]} << 8);

   // stage 3: correction, sign and saturating add
   function automatic logic signed [15:0] sat_add(input logic signed [15:0] acc,
                                                 input logic [22:0] mag,
                                                 input logic [15:0] q0,
                                                 input logic neg);
      logic [23:0]        rem;
      logic [15:0]        q;
      logic signed [17:0] term;
      logic signed [17:0] sum;
      rem  = {1'b0, mag} - (({8'b0, q0} << 8) - {8'b0, q0});
      q    = (rem >= 24'd255) ? q0 + 16'd1 : q0;
      term = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      sum  = {{2{acc[15]}}, acc} + term;
      if (sum > 18'sd32767) begin
         return SAMPLE_MAX;
      end
      if (sum < -18'sd32768) begin
         return SAMPLE_MIN;
      end
      return sum[15:0];
   endfunction

   always_comb begin
      acc_l_in = acc_l_ff;
      acc_r_in = acc_r_ff;
      if (cmd.mix_clear) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (quo_valid_ff) begin
         acc_l_in = sat_add(acc_l_ff, mag_l_ff, q0_l_ff, neg_l_ff);
         acc_r_in = sat_add(acc_r_ff, mag_r_ff, q0_r_ff, neg_r_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_idx_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
         quo_valid_ff  <= 1'b0;
      end else begin
         if (cmd.mix_clear) begin
            mix_idx_ff <= '0;
         end else if (cmd.mix_issue) begin
            mix_idx_ff <= mix_idx_ff + 1'b1;
         end
         rd_valid_ff   <= ram_re;
         prod_valid_ff <= rd_valid_ff;
         quo_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= sel;
      prod_l_ff <= prod_l_full[23:0];
      prod_r_ff <= prod_r_full[23:0];
      mag_l_ff  <= abs_l[22:0];
      mag_r_ff  <= abs_r[22:0];
      q0_l_ff   <= scl_l[31:16];
      q0_r_ff   <= scl_r[31:16];
      neg_l_ff  <= prod_l_ff[23];
      neg_r_ff  <= prod_r_ff[23];
      acc_l_ff  <= acc_l_in;
      acc_r_ff  <= acc_r_in;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (req_ff.func)
            FUNC_START: begin
               rsp_data_ff.result_kind <= KIND_START;
               rsp_data_ff.mix_left    <= '0;
               rsp_data_ff.mix_right   <= '0;
               rsp_data_ff.flag        <= status.start_ok;
            end
            FUNC_QUERY: begin
               rsp_data_ff.result_kind <= KIND_STATUS;
               rsp_data_ff.mix_left    <= '0;
               rsp_data_ff.mix_right   <= '0;
               rsp_data_ff.flag        <= vok && active_ff[sel];
            end
            default: begin
               rsp_data_ff.result_kind <= KIND_MIX;
               rsp_data_ff.mix_left    <= acc_l_ff;
               rsp_data_ff.mix_right   <= acc_r_ff;
               rsp_data_ff.flag        <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.func       = req_ff.func;
   assign status.vok        = vok;
   assign status.start_ok   = vok && (req_ff.frame_count != 15'd0);
   assign status.pipe_busy  = rd_valid_ff | prod_valid_ff | quo_valid_ff;
   assign status.last_voice = (mix_idx_ff == VOICE_LAST);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

// ----- src/eight_voice_pcm_mixer.sv -----
// channel  ports                           moves
// request  req_valid, req_ready, req_data  one command: load, start, gains, stop, query, mix
// response rsp_valid, rsp_ready, rsp_data  mixed frame, playing status or start status
//
// one request at a time; req_ready is high only while the controller is idle
// load, stop and unused codes just decode; gains add multiply and divide steps (not for a
// voice out of range); query responds; start adds those steps when accepted, then responds
// mix reads a frame per playing voice; multiply, divide-by-255, saturate stages drain
// reset (synchronous, active high) stops all voices, zeroes gains; frame memory is kept
// a stalled response blocks the next request with a result to send and all that follow it
`timescale 1ns / 1ps

module eight_voice_pcm_mixer #(
   parameter int VOICES      = evpm_pkg::VOICES_DEF,
   parameter int FRAME_DEPTH = evpm_pkg::FRAME_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  evpm_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output evpm_pkg::rsp_type   rsp_data
);

   import evpm_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: decodes the captured request and walks voices during a mix
   evpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: voice table, frame memory, gain math, mix pipeline, output register
   evpm_datapath #(
      .VOICES      (VOICES),
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/evpm_mix_checker.sv -----
`timescale 1ns / 1ps

module evpm_mix_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  evpm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  evpm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import evpm_pkg::*;

   localparam int VOICE_NUM   = VOICES_DEF;
   localparam int FRAME_SLOTS = FRAME_DEPTH_DEF;

   // frame memory image and per-voice playback state
   bit [31:0] frames [FRAME_SLOTS];
   bit        playing [VOICE_NUM];
   int        base_addr [VOICE_NUM];
   int        length [VOICE_NUM];
   int        position [VOICE_NUM];
   int        left_gain [VOICE_NUM];
   int        right_gain [VOICE_NUM];
   rsp_type   mix_status_q [$];
   int        mismatches = 0;

   function automatic int gain_from(input int num, input int vol);
      int g;
      g = (num * vol) / 127;
      if (g < 0) begin
         g = 0;
      end else if (g > 255) begin
         g = 255;
      end
      return g;
   endfunction

   function automatic int clip_sample(input int x);
      if (x > 32767) begin
         return 32767;
      end else if (x < -32768) begin
         return -32768;
      end
      return x;
   endfunction

   function automatic void store_gains(input int v, input req_type r);
      int vol;
      int sep;
      vol = int'(r.volume);
      sep = int'(r.separation);
      left_gain[v]  = gain_from(254 - sep, vol);
      right_gain[v] = gain_from(sep, vol);
   endfunction

   // applies one request to the voice state and queues the response it causes
   function automatic void mixer_step(input req_type r);
      int                 v;
      bit                 vok;
      int                 lsum;
      int                 rsum;
      int                 s;
      logic signed [15:0] half;
      bit [31:0]          fr;
      rsp_type            reply;
      v     = int'(r.voice);
      vok   = v < VOICE_NUM;
      reply = '0;
      case (r.func)
         FUNC_LOAD: begin
            frames[int'(r.frame_address) % FRAME_SLOTS] = {r.load_right, r.load_left};
         end
         FUNC_START: begin
            reply.result_kind = KIND_START;
            if (vok && r.frame_count != 0) begin
               base_addr[v] = int'(r.frame_address);
               length[v]    = int'(r.frame_count);
               position[v]  = 0;
               playing[v]   = 1'b1;
               store_gains(v, r);
               reply.flag = 1'b1;
            end
            mix_status_q.push_back(reply);
         end
         FUNC_GAINS: begin
            if (vok) begin
               store_gains(v, r);
            end
         end
         FUNC_STOP: begin
            if (vok) begin
               playing[v] = 1'b0;
            end
         end
         FUNC_QUERY: begin
            reply.result_kind = KIND_STATUS;
            reply.flag        = vok && playing[v];
            mix_status_q.push_back(reply);
         end
         FUNC_MIX: begin
            lsum = 0;
            rsum = 0;
            for (int i = 0; i < VOICE_NUM; i++) begin
               if (playing[i]) begin
                  if (position[i] >= length[i]) begin
                     playing[i] = 1'b0;
                  end else begin
                     fr   = frames[(base_addr[i] + position[i]) % FRAME_SLOTS];
                     half = fr[15:0];
                     s    = half;
                     lsum = clip_sample(lsum + (s * left_gain[i]) / 255);
                     half = fr[31:16];
                     s    = half;
                     rsum = clip_sample(rsum + (s * right_gain[i]) / 255);
                     position[i] = (position[i] + 1) & 32'h7FFF;
                  end
               end
            end
            reply.result_kind = KIND_MIX;
            reply.mix_left    = 16'(lsum);
            reply.mix_right   = 16'(rsum);
            mix_status_q.push_back(reply);
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      bit      bad;
      if (reset) begin
         for (int i = 0; i < VOICE_NUM; i++) begin
            playing[i]    = 1'b0;
            base_addr[i]  = 0;
            length[i]     = 0;
            position[i]   = 0;
            left_gain[i]  = 0;
            right_gain[i] = 0;
         end
         mix_status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mix_status_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: response with none outstanding: kind %0d L %0d R %0d flag %0d",
                           $time, rsp_data.result_kind, rsp_data.mix_left,
                           rsp_data.mix_right, rsp_data.flag);
               end
            end else begin
               want = mix_status_q.pop_front();
               bad  = (rsp_data.result_kind !== want.result_kind)
                   || (rsp_data.mix_left !== want.mix_left)
                   || (rsp_data.mix_right !== want.mix_right)
                   || (rsp_data.flag !== want.flag);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: response mismatch: want kind %0d L %0d R %0d flag %0d",
                              $time, want.result_kind, want.mix_left, want.mix_right,
                              want.flag);
                     $display("%0t:                    got  kind %0d L %0d R %0d flag %0d",
                              $time, rsp_data.result_kind, rsp_data.mix_left,
                              rsp_data.mix_right, rsp_data.flag);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            mixer_step(req_data);
         end
      end
      fail_count <= mismatches;
      pending    <= mix_status_q.size();
   end

endmodule

// ----- verif/tb_eight_voice_pcm_mixer.sv -----
`timescale 1ns / 1ps

module tb_eight_voice_pcm_mixer;
   import evpm_pkg::*;

   localparam int VOICE_NUM      = VOICES_DEF;
   localparam int FRAME_SLOTS    = FRAME_DEPTH_DEF;
   localparam int REQUEST_TARGET = 500;
   localparam int TAIL_CYCLES    = 40;

   // function codes with no meaning to the block
   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;

   // receiver stall patterns
   typedef enum int {
      ACCEPT_ALL,
      ACCEPT_HALF,
      ACCEPT_SPARSE,
      ACCEPT_PERIODIC
   } accept_mode_type;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   int         fail_count;
   int         pending;

   // stimulus bookkeeping: which frames hold data and where each voice reads next,
   // so that no mix ever touches a frame that was never loaded
   bit         loaded [FRAME_SLOTS];
   bit         sh_on [VOICE_NUM];
   int         sh_base [VOICE_NUM];
   int         sh_len [VOICE_NUM];
   int         sh_pos [VOICE_NUM];

   int         burst_left = 0;
   int         sent_count = 0;
   accept_mode_type ready_mode = ACCEPT_ALL;
   int         mode_left  = 0;

   eight_voice_pcm_mixer #(
      .VOICES      (VOICE_NUM),
      .FRAME_DEPTH (FRAME_SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   evpm_mix_checker mixer_watch (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs or a response never shows up
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // response side: switch at random between stall patterns,
   // including stretches where every response is taken at once
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= accept_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            ACCEPT_ALL:    rsp_ready <= 1'b1;
            ACCEPT_HALF:   rsp_ready <= 1'($urandom_range(0, 1));
            ACCEPT_SPARSE: rsp_ready <= ($urandom_range(0, 4) == 0);
            default:       rsp_ready <= ((mode_left % 16) < 3);
         endcase
      end
   end

   // random sample, with the two extremes picked often
   function automatic int pick_sample();
      case ($urandom_range(0, 7))
         0:       return -32768;
         1:       return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // present one request and hold it until accepted; returns at the accepting edge
   // so the next request can follow back to back
   task automatic send_request(input req_type r);
      int gap;
      if (burst_left == 0) begin
         // end of a burst: maybe drop valid for a while, then start a new burst
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // one request, preceded for a mix by loads of any frame a playing voice
   // is about to read that holds nothing yet
   task automatic run_request(input req_type r);
      int      a;
      req_type fill;
      if (r.func == FUNC_MIX) begin
         for (int i = 0; i < VOICE_NUM; i++) begin
            if (sh_on[i] && sh_pos[i] < sh_len[i]) begin
               a = (sh_base[i] + sh_pos[i]) % FRAME_SLOTS;
               if (!loaded[a]) begin
                  fill               = '0;
                  fill.func          = FUNC_LOAD;
                  fill.frame_address = 14'(a);
                  fill.load_left     = 16'(pick_sample());
                  fill.load_right    = 16'(pick_sample());
                  send_request(fill);
                  loaded[a] = 1'b1;
               end
            end
         end
      end
      send_request(r);
      // follow the voices so later mixes know which frames they read
      case (r.func)
         FUNC_LOAD: begin
            loaded[int'(r.frame_address) % FRAME_SLOTS] = 1'b1;
         end
         FUNC_START: begin
            if (r.frame_count != 0) begin
               sh_on[r.voice]   = 1'b1;
               sh_base[r.voice] = int'(r.frame_address);
               sh_len[r.voice]  = int'(r.frame_count);
               sh_pos[r.voice]  = 0;
            end
         end
         FUNC_STOP: begin
            sh_on[r.voice] = 1'b0;
         end
         FUNC_MIX: begin
            for (int i = 0; i < VOICE_NUM; i++) begin
               if (sh_on[i]) begin
                  if (sh_pos[i] >= sh_len[i]) begin
                     sh_on[i] = 1'b0;
                  end else begin
                     sh_pos[i]++;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic issue_fields(input logic [2:0] f, input int v, input int addr,
                               input int cnt, input int vol, input int sep,
                               input int left, input int right);
      req_type r;
      r               = '0;
      r.func          = f;
      r.voice         = 3'(v);
      r.frame_address = 14'(addr);
      r.frame_count   = 15'(cnt);
      r.volume        = 7'(vol);
      r.separation    = 8'(sep);
      r.load_left     = 16'(left);
      r.load_right    = 16'(right);
      run_request(r);
   endtask

   initial begin
      int         pick;
      int         v;
      int         addr;
      int         cnt;
      logic [2:0] f;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // idle block: nothing playing, empty mix is silent
      issue_fields(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0);
      // extreme samples at the top and bottom of memory
      issue_fields(FUNC_LOAD, 0, FRAME_SLOTS - 1, 0, 0, 0, 32767, -32768);
      issue_fields(FUNC_LOAD, 0, 0, 0, 0, 0, -32768, 32767);
      // four voices from the last frame, the first three for two frames so their second wraps to zero:
      // full left, full right, separation past the right edge, zero volume
      issue_fields(FUNC_START, 0, FRAME_SLOTS - 1, 2, 127, 0, 0, 0);
      issue_fields(FUNC_START, 1, FRAME_SLOTS - 1, 2, 127, 254, 0, 0);
      issue_fields(FUNC_START, 2, FRAME_SLOTS - 1, 2, 127, 255, 0, 0);
      issue_fields(FUNC_START, 3, FRAME_SLOTS - 1, 1, 0, 0, 0, 0);
      // zero-length start is refused and leaves the voice idle
      issue_fields(FUNC_START, 4, 100, 0, 127, 127, 0, 0);
      issue_fields(FUNC_QUERY, 4, 0, 0, 0, 0, 0, 0);
      // gains on a voice that is not playing
      issue_fields(FUNC_GAINS, 7, 0, 0, 127, 127, 0, 0);
      // first mix saturates low on the right, second saturates high
      issue_fields(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_QUERY, 3, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0);
      // voices still read as playing after their last frame until the next mix
      issue_fields(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0);
      // a voice as long as the whole frame memory, a gain change while playing, then stop it
      issue_fields(FUNC_START, 5, 5, FRAME_SLOTS, 64, 200, 0, 0);
      issue_fields(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_GAINS, 5, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_STOP, 5, 0, 0, 0, 0, 0, 0);
      issue_fields(FUNC_QUERY, 5, 0, 0, 0, 0, 0, 0);
      // unused function codes do nothing
      issue_fields(FUNC_SPARE_A, 7, FRAME_SLOTS - 1, 32767, 127, 255, -1, -1);
      issue_fields(FUNC_SPARE_B, 7, FRAME_SLOTS - 1, 32767, 127, 255, -1, -1);
      // all-ones count field and a start near the top of memory, so its reads wrap
      issue_fields(FUNC_START, 7, FRAME_SLOTS - 4, 32767, 127, 255, 0, 0);
      issue_fields(FUNC_MIX, 0, 0, 0, 0, 0, 0, 0);

      // --- random part: mostly loads, starts and mixes with random content ---
      while (sent_count < REQUEST_TARGET) begin
         pick = $urandom_range(0, 99);
         v    = $urandom_range(0, VOICE_NUM - 1);
         case ($urandom_range(0, 7))
            0:       addr = $urandom_range(0, FRAME_SLOTS - 1);
            1:       addr = FRAME_SLOTS - $urandom_range(1, 8);
            default: addr = $urandom_range(0, 255);
         endcase
         case ($urandom_range(0, 9))
            0:       cnt = 0;
            1:       cnt = $urandom_range(0, 32767);
            2:       cnt = FRAME_SLOTS;
            default: cnt = $urandom_range(1, 48);
         endcase
         if (pick < 12) begin
            f = FUNC_LOAD;
         end else if (pick < 30) begin
            f = FUNC_START;
         end else if (pick < 38) begin
            f = FUNC_GAINS;
         end else if (pick < 44) begin
            f = FUNC_STOP;
         end else if (pick < 56) begin
            f = FUNC_QUERY;
         end else if (pick < 96) begin
            f = FUNC_MIX;
         end else begin
            f = ($urandom_range(0, 1) == 0) ? FUNC_SPARE_A : FUNC_SPARE_B;
         end
         issue_fields(f, v, addr, cnt, $urandom_range(0, 127), $urandom_range(0, 255),
                      pick_sample(), pick_sample());
      end

      // drain: wait for every outstanding response, then let the block settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
